@@ src/tkch_pkg.sv @@
// Shared types, event codes and helper functions for the two-key click and hold detector.
`timescale 1ns / 1ps

package tkch_pkg;

    localparam int KEY_W = 2;
    localparam int MS_W  = 8;
    localparam int SUM_W = 16;
    localparam int CFG_W = 16;
    localparam int EV_W  = 3;
    localparam int IDX_W = 2;

    localparam logic [KEY_W-1:0] KEYS_NONE = 2'b00;
    localparam logic [KEY_W-1:0] KEYS_BOTH = 2'b11;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_HOLD_TIME    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CLICK_TIME   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RELEASE_TIME = 2'd2;

    // Event codes.
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_UP_CLICK   = 3'd1;
    localparam logic [EV_W-1:0] EV_DOWN_CLICK = 3'd2;
    localparam logic [EV_W-1:0] EV_BOTH_CLICK = 3'd3;
    localparam logic [EV_W-1:0] EV_UP_HOLD    = 3'd4;
    localparam logic [EV_W-1:0] EV_DOWN_HOLD  = 3'd5;
    localparam logic [EV_W-1:0] EV_BOTH_HOLD  = 3'd6;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] click_ms;
        logic [CFG_W-1:0] rel_ms;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] keys;
        logic [MS_W-1:0]  ms;
    } scan_t;

    function automatic logic [EV_W-1:0] click_code(input logic [KEY_W-1:0] set);
        logic [EV_W-1:0] code;
        case (set)
            2'b01:   code = EV_UP_CLICK;
            2'b10:   code = EV_DOWN_CLICK;
            2'b11:   code = EV_BOTH_CLICK;
            default: code = EV_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [EV_W-1:0] hold_code(input logic [KEY_W-1:0] set);
        logic [EV_W-1:0] code;
        case (set)
            2'b01:   code = EV_UP_HOLD;
            2'b10:   code = EV_DOWN_HOLD;
            2'b11:   code = EV_BOTH_HOLD;
            default: code = EV_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ src/two_key_click_hold_detector.sv @@
// Top level of the two-key click and hold detector with its stream channels.
`timescale 1ns / 1ps

// Usage:
// Scan items enter on the s_ stream channel; each carries the raw active-low
// levels of the up and down keys and the milliseconds since the last scan.
// Every accepted item produces exactly one result item on the m_ channel
// carrying an event code (none, click or hold of up, down or both keys).
// An item is registered on entry and its result is registered on exit; the
// item moves on when the result register is free or being taken. With the
// receiver always ready one item is accepted and one result delivered every
// cycle. When the receiver stalls, the result register holds its item, the
// entry register fills, and s_tready falls until the result is taken; no item
// is lost or repeated. Times are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which
// the block does not enforce. Synchronous reset (aresetn low) empties both
// registers, returns to waiting for a press, clears the press set and
// accumulator, and loads hold 1000 ms, click 20 ms and release 50 ms.

module two_key_click_hold_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [1:0] key_pins, [9:2] elapsed_ms
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [2:0] event_code
    input  logic                        cfg_we,
    input  logic [tkch_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tkch_pkg::CFG_W-1:0]  cfg_wdata
);
    import tkch_pkg::*;

    cfg_t             cfg;
    scan_t            scan;
    logic [EV_W-1:0]  evt;

    logic             in_valid_reg;
    logic [KEY_W-1:0] keys_reg;
    logic [MS_W-1:0]  ms_reg;
    logic             out_valid_reg;
    logic [EV_W-1:0]  evt_reg;
    logic             advance;

    // The entry item moves into the result register whenever that is free.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign scan.valid = in_valid_reg && advance;
    assign scan.keys  = ~keys_reg;
    assign scan.ms    = ms_reg;

    tkch_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tkch_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .scan    (scan),
        .evt     (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            keys_reg <= s_tdata[KEY_W-1:0];
            ms_reg   <= s_tdata[KEY_W+MS_W-1:KEY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan.valid) begin
            evt_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-EV_W){1'b0}}, evt_reg};

`ifndef SYNTHESIS
    // The input side only stalls when both registers hold an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free register");

    // A scan with zero elapsed time always yields no event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan.valid && ms_reg == '0) |=> (m_tvalid && m_tdata[EV_W-1:0] == EV_NONE))
        else $error("zero elapsed scan produced an event");
`endif

endmodule

@@ src/tkch_cfg.sv @@
// Configuration register file holding the hold, click and release times.
`timescale 1ns / 1ps

module tkch_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [tkch_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tkch_pkg::CFG_W-1:0]  cfg_wdata,
    output tkch_pkg::cfg_t              cfg
);
    import tkch_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ms  <= CFG_W'(1000);
            cfg_reg.click_ms <= CFG_W'(20);
            cfg_reg.rel_ms   <= CFG_W'(50);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HOLD_TIME:    cfg_reg.hold_ms  <= cfg_wdata;
                REG_CLICK_TIME:   cfg_reg.click_ms <= cfg_wdata;
                REG_RELEASE_TIME: cfg_reg.rel_ms   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/tkch_fsm.sv @@
// Phase state machine: debounce, click and hold; one scan item per cycle while valid.
`timescale 1ns / 1ps

module tkch_fsm (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tkch_pkg::cfg_t             cfg,
    input  tkch_pkg::scan_t            scan,
    output logic [tkch_pkg::EV_W-1:0]  evt
);
    import tkch_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [KEY_W-1:0] press_reg, press_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic             active;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic             held_long;
    logic             click_ok;
    logic             quiet_long;

    // A scan with zero elapsed time leaves everything untouched.
    assign active     = scan.valid && (scan.ms != '0);
    assign sum_wide   = {1'b0, sum_reg} + {{(SUM_W+1-MS_W){1'b0}}, scan.ms};
    assign sum_sat    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign held_long  = sum_sat >= cfg.hold_ms;
    assign click_ok   = sum_reg >= cfg.click_ms;
    assign quiet_long = sum_sat >= cfg.rel_ms;

    always_comb begin
        phase_next = phase_reg;
        press_next = press_reg;
        sum_next   = sum_reg;
        if (active) begin
            case (phase_reg)
                PH_DEBOUNCE: begin
                    if (scan.keys == press_reg) begin
                        if (held_long) begin
                            phase_next = PH_HOLD;
                            sum_next   = '0;
                        end else begin
                            sum_next = sum_sat;
                        end
                    end else if (scan.keys == KEYS_NONE) begin
                        phase_next = PH_WAIT;
                        sum_next   = '0;
                    end else if (press_reg != KEYS_BOTH && scan.keys == KEYS_BOTH) begin
                        press_next = KEYS_BOTH;
                        sum_next   = '0;
                    end else if (press_reg == KEYS_BOTH) begin
                        if (click_ok) begin
                            phase_next = PH_HOLD;
                        end else begin
                            press_next = scan.keys;
                        end
                        sum_next = '0;
                    end else begin
                        press_next = scan.keys;
                        sum_next   = '0;
                    end
                end
                PH_HOLD: begin
                    if (scan.keys == KEYS_NONE) begin
                        if (quiet_long) begin
                            phase_next = PH_WAIT;
                            sum_next   = '0;
                        end else begin
                            sum_next = sum_sat;
                        end
                    end else begin
                        sum_next = '0;
                    end
                end
                default: begin
                    if (scan.keys != KEYS_NONE) begin
                        phase_next = PH_DEBOUNCE;
                        press_next = scan.keys;
                        sum_next   = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        evt = EV_NONE;
        if (active) begin
            case (phase_reg)
                PH_DEBOUNCE: begin
                    if (scan.keys == press_reg) begin
                        if (held_long) begin
                            evt = hold_code(press_reg);
                        end
                    end else if (scan.keys == KEYS_NONE) begin
                        if (click_ok) begin
                            evt = click_code(press_reg);
                        end
                    end else if (press_reg == KEYS_BOTH && click_ok) begin
                        evt = EV_BOTH_CLICK;
                    end
                end
                default: evt = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            press_reg <= KEYS_NONE;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            press_reg <= press_next;
            sum_reg   <= sum_next;
        end
    end

`ifndef SYNTHESIS
    // While debouncing there is always at least one key in the press set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DEBOUNCE |-> press_reg != KEYS_NONE)
        else $error("debounce phase with empty press set");

    // Outside debounce no event can be produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_DEBOUNCE |-> evt == EV_NONE)
        else $error("event reported outside debounce phase");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the two-key click and hold detector.
`timescale 1ns / 1ps

module tb;
    import tkch_pkg::*;

    localparam logic [KEY_W-1:0] KEY_UP     = 2'b01;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 2'b10;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 20;

    // Keeps its own copy of the key state and the times, and the events still owed.
    class scan_scoreboard;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] click_ms;
        logic [CFG_W-1:0] rel_ms;
        phase_t           phase;
        logic [KEY_W-1:0] held;
        logic [SUM_W-1:0] acc;
        logic [EV_W-1:0]  owed_events[$];
        int               errors;
        int               scans;

        function new();
            hold_ms  = 16'd1000;
            click_ms = 16'd20;
            rel_ms   = 16'd50;
            phase    = PH_WAIT;
            held     = KEYS_NONE;
            acc      = '0;
            errors   = 0;
            scans    = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_HOLD_TIME:    hold_ms  = val;
                REG_CLICK_TIME:   click_ms = val;
                REG_RELEASE_TIME: rel_ms   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        function logic [EV_W-1:0] event_for(logic [KEY_W-1:0] set, bit is_hold);
            case (set)
                KEY_UP:    return is_hold ? EV_UP_HOLD : EV_UP_CLICK;
                KEY_DOWN:  return is_hold ? EV_DOWN_HOLD : EV_DOWN_CLICK;
                KEYS_BOTH: return is_hold ? EV_BOTH_HOLD : EV_BOTH_CLICK;
                default:   return EV_NONE;
            endcase
        endfunction

        function void add_ms(logic [MS_W-1:0] ms);
            logic [SUM_W:0] sum;
            sum = acc + ms;
            acc = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
        endfunction

        function void note_scan(logic [KEY_W-1:0] pins, logic [MS_W-1:0] ms);
            logic [KEY_W-1:0] keys;
            logic [EV_W-1:0]  ev;
            keys = ~pins;
            ev   = EV_NONE;
            scans++;
            if (ms != 0) begin
                case (phase)
                    PH_DEBOUNCE: begin
                        if (keys == held) begin
                            add_ms(ms);
                            if (acc >= hold_ms) begin
                                phase = PH_HOLD;
                                acc   = '0;
                                ev    = event_for(held, 1'b1);
                            end
                        end else if (keys == KEYS_NONE) begin
                            if (acc >= click_ms)
                                ev = event_for(held, 1'b0);
                            phase = PH_WAIT;
                            acc   = '0;
                        end else if (held != KEYS_BOTH && keys == KEYS_BOTH) begin
                            held = KEYS_BOTH;
                            acc  = '0;
                        end else if (held == KEYS_BOTH) begin
                            // One key of a both press let go.
                            if (acc >= click_ms) begin
                                ev    = EV_BOTH_CLICK;
                                phase = PH_HOLD;
                            end else begin
                                held = keys;
                            end
                            acc = '0;
                        end else begin
                            held = keys;
                            acc  = '0;
                        end
                    end
                    PH_HOLD: begin
                        if (keys == KEYS_NONE) begin
                            add_ms(ms);
                            if (acc >= rel_ms) begin
                                phase = PH_WAIT;
                                acc   = '0;
                            end
                        end else begin
                            acc = '0;
                        end
                    end
                    default: begin
                        if (keys != KEYS_NONE) begin
                            acc   = '0;
                            phase = PH_DEBOUNCE;
                            held  = keys;
                        end
                    end
                endcase
            end
            owed_events.push_back(ev);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task check_event(logic [EV_W-1:0] got);
            logic [EV_W-1:0] want;
            if (owed_events.size() == 0) begin
                report($sformatf("event %0d arrived with none owed", got));
                return;
            end
            want = owed_events.pop_front();
            if (got !== want)
                report($sformatf("event_code %0d, wanted %0d", got, want));
        endtask
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    scan_scoreboard sb;
    bit idle_on = 1'b1;
    int rx_wait = 0;
    int events_seen = 0;

    two_key_click_hold_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

    // Result side: a random stall after each item while idle_on is set, and now and then
    // a long one so that both registers fill and the input stalls.
    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_event(m_tdata[EV_W-1:0]);
            events_seen++;
            if (events_seen == 350 || events_seen == 1350)
                rx_wait = 300;
            else
                rx_wait = idle_on ? $urandom_range(0, 7) : 0;
        end
    end

    task automatic send_scan(input logic [KEY_W-1:0] pins, input logic [MS_W-1:0] ms);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ms, pins};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_scan(pins, ms);
        @(negedge aclk);
    endtask

    task automatic press(input logic [KEY_W-1:0] keys, input logic [MS_W-1:0] ms);
        send_scan(~keys, ms);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_times(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] click,
                             input logic [CFG_W-1:0] rel);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_CLICK_TIME, click);
        write_reg(REG_RELEASE_TIME, rel);
    endtask

    // Stop offering items and let every owed event drain out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Runs with the reset times: hold 1000, click 20, release 50.
    task automatic directed_scans();
        press(KEY_UP, 8'd0);             // ignored scan
        press(KEY_UP, 8'd10);
        press(KEY_UP, 8'd10);
        press(KEY_UP, 8'd10);
        press(KEYS_NONE, 8'd5);          // up click
        press(KEY_UP, 8'd3);
        press(KEYS_BOTH, 8'd3);          // down joins while debouncing
        press(KEYS_BOTH, 8'd25);
        press(KEY_UP, 8'd1);             // both click, then hold phase
        press(KEYS_NONE, 8'd30);
        press(KEY_DOWN, 8'd1);           // a press restarts the release time
        press(KEYS_NONE, 8'd255);
        press(KEYS_BOTH, 8'd4);
        press(KEYS_BOTH, 8'd5);
        press(KEY_DOWN, 8'd5);           // early release of one key keeps the other
        press(KEY_UP, 8'd5);
        press(KEYS_NONE, 8'd5);          // too short for a click
        repeat (5) press(KEY_DOWN, 8'd255);
        press(KEYS_NONE, 8'd255);
        repeat (5) press(KEYS_BOTH, 8'd255);
        press(KEYS_NONE, 8'd60);
    endtask

    // Long press and long release that drive the accumulator into saturation.
    task automatic saturation_scans();
        repeat (259) press(KEY_UP, 8'd254);
        press(KEY_UP, 8'd255);
        repeat (258) press(KEYS_NONE, 8'd254);
        press(KEYS_NONE, 8'd255);
        press(KEYS_BOTH, 8'd10);
        press(KEYS_NONE, 8'd10);
    endtask

    // Key sets that mostly stay put for a while, with short glitches mixed in.
    task automatic random_scans(input int n, input int ms_max);
        logic [KEY_W-1:0] keys;
        logic [KEY_W-1:0] pins;
        logic [MS_W-1:0]  ms;
        int               r;
        keys = KEYS_NONE;
        repeat (n) begin
            if ($urandom_range(0, 99) < 12)
                keys = KEY_W'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 5)
                ms = 8'd0;
            else if (r < 10)
                ms = 8'd255;
            else
                ms = MS_W'($urandom_range(1, ms_max));
            pins = ~keys;
            if ($urandom_range(0, 19) == 0)
                pins = KEY_W'($urandom_range(0, 3));
            send_scan(pins, ms);
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_scans();
        settle();

        set_times(16'd0, 16'd0, 16'd0);
        random_scans(200, 20);
        settle();

        set_times(16'd60000, 16'd60000, 16'd60000);
        random_scans(150, 255);
        settle();

        set_times(16'hFFFF, 16'd0, 16'hFFFF);
        write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 16'hFFFF)));
        saturation_scans();
        settle();

        for (int p = 0; p < 6; p++) begin
            idle_on = (p % 3 != 2);
            set_times(CFG_W'($urandom_range(50, 600)), CFG_W'($urandom_range(0, 100)),
                      CFG_W'($urandom_range(0, 200)));
            random_scans(150, 40);
            settle();
        end

        repeat (10) @(negedge aclk);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
